// File: src/b2da_pkg.sv
package b2da_pkg;

  localparam int unsigned DefaultValueWidth = 32;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  typedef struct packed {
    logic [31:0] value;
    logic        is_signed;
    logic        append_newline;
  } item_in_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } item_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StDigit,
    StCr,
    StLf
  } state_e;

  typedef enum logic [1:0] {
    SelMinus,
    SelDigit,
    SelCr,
    SelLf
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      convert;
    logic      shift;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic nl;
    logic top_zero;
  } dp_status_t;

endpackage

// File: src/b2da_datapath.sv
module b2da_datapath import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_in_t   item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output item_out_t  result_o,
  output logic       result_valid_o
);

  localparam int unsigned PadW      = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int unsigned NumDigits = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned BcdW      = NumDigits * 4;

  logic [PadW-1:0]        bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic                   neg_q, nl_q;
  item_out_t              out_q, out_d;
  logic                   valid_q;

  logic [63:0]            raw;
  logic [VALUE_WIDTH-1:0] val_w;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg_in;
  logic [3:0]             top;

  assign raw    = {32'b0, item_i.value};
  assign val_w  = raw[VALUE_WIDTH-1:0];
  assign neg_in = item_i.is_signed & val_w[VALUE_WIDTH-1];
  assign mag    = neg_in ? (~val_w + VALUE_WIDTH'(1)) : val_w;
  assign top    = bcd_q[BcdW-1 -: 4];

  // two shift-add-3 steps per cycle
  always_comb begin
    logic [BcdW-1:0] b;
    logic [PadW-1:0] s;
    b = bcd_q;
    s = bin_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = '0;
      bin_d[VALUE_WIDTH-1:0] = mag;
      bcd_d = '0;
    end else if (cmd_i.convert) begin
      for (int st = 0; st < 2; st++) begin
        for (int d = 0; d < NumDigits; d++) begin
          if (b[d*4 +: 4] >= 4'd5) begin
            b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
          end
        end
        b = {b[BcdW-2:0], s[PadW-1]};
        s = {s[PadW-2:0], 1'b0};
      end
      bin_d = s;
      bcd_d = b;
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'b0};
    end
  end

  always_comb begin
    out_d.last_char = cmd_i.last;
    case (cmd_i.sel)
      SelMinus: out_d.ascii_char = CharMinus;
      SelDigit: out_d.ascii_char = CharZero + {4'b0, top};
      SelCr:    out_d.ascii_char = CharCr;
      SelLf:    out_d.ascii_char = CharLf;
      default:  out_d.ascii_char = CharZero;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    if (cmd_i.load) begin
      neg_q <= neg_in;
      nl_q  <= item_i.append_newline;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign status_o.neg      = neg_q;
  assign status_o.nl       = nl_q;
  assign status_o.top_zero = (top == 4'd0);
  assign result_o          = out_q;
  assign result_valid_o    = valid_q;

endmodule

// File: src/b2da_ctrl.sv
module b2da_ctrl import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned PadW      = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int unsigned Steps     = PadW / 2;
  localparam int unsigned NumDigits = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned StepW     = $clog2(Steps);
  localparam int unsigned DigW      = $clog2(NumDigits + 1);

  state_e            state_q, state_d;
  logic [StepW-1:0]  step_q;
  logic [DigW-1:0]   digit_q;
  logic              first_q;
  logic              started_q;
  logic              digit_one;

  assign digit_one = (digit_q == DigW'(1));
  assign busy      = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StConv;
      StConv:  if (step_q == StepW'(Steps - 1)) state_d = StDigit;
      StDigit: begin
        if (digit_one) state_d = status_i.nl ? StCr : StIdle;
      end
      StCr:    state_d = StLf;
      StLf:    state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = SelDigit;
    case (state_q)
      StIdle: cmd_o.load = start;
      StConv: begin
        cmd_o.convert = 1'b1;
        if (first_q && status_i.neg) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SelMinus;
        end
      end
      StDigit: begin
        cmd_o.shift = 1'b1;
        if (started_q || !status_i.top_zero || digit_one) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = digit_one && !status_i.nl;
        end
      end
      StCr: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SelCr;
      end
      StLf: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SelLf;
        cmd_o.last = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      digit_q   <= '0;
      first_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) begin
        step_q    <= '0;
        digit_q   <= DigW'(NumDigits);
        first_q   <= 1'b1;
        started_q <= 1'b0;
      end else begin
        if (cmd_o.convert) begin
          step_q  <= step_q + StepW'(1);
          first_q <= 1'b0;
        end
        if (cmd_o.shift) begin
          digit_q <= digit_q - DigW'(1);
          if (cmd_o.emit) started_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/binary_to_decimal_ascii.sv
// A leading minus sign is registered for output in the first conversion step; the digits
// follow once the shift-add-3 loop is done, with leading zero slots skipped (last slot shown).
// The 2-bit-per-cycle shift-add-3 loop is followed by a one-slot-per-cycle digit scan over
// D decimal digit slots (10 at 32 bits); CR and LF follow when append_newline is set.
// The receiver cannot stall. A new number is taken only while idle (busy low).
// Reset (async, active low) returns the controller to idle and drops the result strobe.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  item_in_t  item_i,
  output item_out_t result_o,
  output logic      result_valid_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  b2da_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  b2da_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// File: test/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned RandomItems = 150;
  localparam logic [31:0] Radix       = 32'd10;

  typedef struct {
    item_in_t number;
    bit       settle;
  } job_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  item_in_t  item_i = '0;
  item_out_t result_o;
  logic      result_valid_o;

  job_t      jobs_q[$];
  item_out_t text_q[$];

  int unsigned issued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned char_cnt   = 0;
  int unsigned neg_cnt    = 0;
  int unsigned nl_cnt     = 0;
  int unsigned settle_cnt = 0;

  binary_to_decimal_ascii dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Expected text of one number, pushed character by character.
  function automatic void render_decimal(item_in_t num);
    logic [31:0] mag;
    logic [7:0]  txt[$];
    logic [7:0]  digs[$];
    item_out_t   ch;
    mag = num.value;
    if (num.is_signed && num.value[31]) begin
      txt.push_back(CharMinus);
      mag = -num.value;
    end
    do begin
      digs.push_front(CharZero + 8'(mag % Radix));
      mag = mag / Radix;
    end while (mag != 0);
    txt = {txt, digs};
    if (num.append_newline) begin
      txt.push_back(CharCr);
      txt.push_back(CharLf);
    end
    foreach (txt[k]) begin
      ch.ascii_char = txt[k];
      ch.last_char  = (k == txt.size() - 1);
      text_q.push_back(ch);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(8, 45);
  endfunction

  task automatic add_number(logic [31:0] v, bit sgn, bit nl, bit settle);
    job_t j;
    j.number.value          = v;
    j.number.is_signed      = sgn;
    j.number.append_newline = nl;
    j.settle                = settle;
    if (settle) settle_cnt++;
    jobs_q.push_back(j);
  endtask

  // Driver: hold start until taken, then idle for the chosen gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && taken_cnt != issued_cnt) begin
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (jobs_q.size() != 0 && !(jobs_q[0].settle && text_q.size() != 0)) begin
      item_i     <= jobs_q[0].number;
      start      <= 1'b1;
      issued_cnt <= issued_cnt + 1;
      gap_left   <= (burst_left != 0) ? 0 : pick_gap();
      burst_left <= (burst_left != 0) ? burst_left - 1 :
                    (($urandom_range(0, 19) == 0) ? 10 : 0);
      jobs_q.delete(0);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check characters, then register newly taken items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        char_cnt++;
        if (text_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] unexpected char: ascii %02h last %0b", $time,
                     result_o.ascii_char, result_o.last_char);
        end else begin
          if (result_o.ascii_char !== text_q[0].ascii_char ||
              result_o.last_char !== text_q[0].last_char) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] mismatch: expected ascii %02h last %0b, got ascii %02h last %0b",
                       $time, text_q[0].ascii_char, text_q[0].last_char,
                       result_o.ascii_char, result_o.last_char);
          end
          text_q.delete(0);
        end
      end
      if (start && !busy) begin
        taken_cnt++;
        render_decimal(item_i);
        if (item_i.is_signed && item_i.value[31]) neg_cnt++;
        if (item_i.append_newline) nl_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d characters outstanding", cycle_cnt, text_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] v;
    logic [31:0] p;
    int unsigned sel;

    add_number(32'd0,          1'b0, 1'b0, 1'b0);
    add_number(32'd0,          1'b1, 1'b1, 1'b0);
    add_number(32'hFFFF_FFFF,  1'b0, 1'b1, 1'b0);
    add_number(32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0);
    add_number(32'h8000_0000,  1'b1, 1'b1, 1'b0);
    add_number(32'h8000_0000,  1'b0, 1'b0, 1'b0);
    add_number(32'h7FFF_FFFF,  1'b1, 1'b1, 1'b0);
    add_number(32'h7FFF_FFFF,  1'b0, 1'b0, 1'b1);
    add_number(32'd9,          1'b0, 1'b0, 1'b0);
    add_number(32'd10,         1'b1, 1'b0, 1'b0);
    add_number(32'd99,         1'b0, 1'b1, 1'b0);
    add_number(32'd100,        1'b1, 1'b1, 1'b0);
    add_number(32'd999999999,  1'b0, 1'b0, 1'b0);
    add_number(32'd1000000000, 1'b1, 1'b0, 1'b0);
    add_number(-32'd10,        1'b1, 1'b0, 1'b1);
    add_number(-32'd1000000000, 1'b1, 1'b1, 1'b0);
    add_number(32'd1,          1'b0, 1'b1, 1'b0);
    add_number(32'hAAAA_5555,  1'b1, 1'b0, 1'b0);
    add_number(32'h5555_AAAA,  1'b0, 1'b0, 1'b0);

    for (int n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0, 1: v = $urandom;
        2: v = $urandom_range(0, 120);
        3: v = -$urandom_range(1, 120);
        4: begin
          p = 32'd1;
          repeat ($urandom_range(0, 9)) p = p * Radix;
          v = p + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      add_number(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 24) == 0);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (jobs_q.size() != 0 || start || text_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative, %0d with CR/LF) into %0d characters.",
             taken_cnt, neg_cnt, nl_cnt, char_cnt);
    $display("Random start gaps and %0d drain waits; %0d mismatches.", settle_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/b2da_pkg.sv
src/b2da_datapath.sv
src/b2da_ctrl.sv
src/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_tb.sv
